// File: sv/fwt2d_pkg.sv
// Shared definitions for the two-dimensional Fenwick tree core.
// Holds field widths, operation and register codes, the sequencer control
// struct and the lowest-set-bit helper. No dependencies.
package fwt2d_pkg;

  localparam int FWT2D_MAX_ROWS = 64;
  localparam int FWT2D_MAX_COLS = 64;

  localparam int DATA_W    = 64;
  localparam int COORD_W   = 7;
  localparam int WALK_W    = 8;  // walk index, wide enough for i + lowbit(i)
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 8;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 64;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WHOLE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 8'd1;

  typedef struct packed {
    logic start;    // item accepted, clear the accumulator
    logic rd;       // memory read this cycle
    logic acc;      // read data is to be accumulated next cycle
    logic rd_neg;   // accumulate with negative sign
    logic wr;       // memory write this cycle
    logic wr_zero;  // write data is zero (clearing pass)
    logic fin;      // result is loaded into the output register
    logic err;      // result carries the out-of-range status
  } fwt2d_ctl_t;

  function automatic logic [WALK_W-1:0] low_bit(input logic [WALK_W-1:0] v);
    low_bit = v & (~v + 1'b1);
  endfunction

endpackage

// File: sv/fwt2d_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module fwt2d_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/fwt2d_seq.sv
// Operation sequencer: clearing pass, prefix walks and point-add updates.
// Generates cell addresses and per-cycle control; depends on fwt2d_pkg.
module fwt2d_seq
  import fwt2d_pkg::*;
#(
  parameter int MAX_ROWS = FWT2D_MAX_ROWS,
  parameter int MAX_COLS = FWT2D_MAX_COLS,
  parameter int AW       = ((MAX_ROWS * MAX_COLS) > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_clear,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  mode,
  input  logic [COORD_W-1:0] row_lo,
  input  logic [COORD_W-1:0] col_lo,
  input  logic [COORD_W-1:0] row_hi,
  input  logic [COORD_W-1:0] col_hi,
  input  logic [COORD_W-1:0] rows,
  input  logic [COORD_W-1:0] cols,
  input  logic               out_free,
  output logic [AW-1:0]      ram_addr,
  output fwt2d_ctl_t         ctl
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_WALK   = 6'b000100,
    S_ADD_RD = 6'b001000,
    S_ADD_WR = 6'b010000,
    S_DONE   = 6'b100000
  } seq_state_t;

  seq_state_t         state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [WALK_W-1:0]  i_r, i_nxt, j_r, j_nxt, cstart_r, cstart_nxt;
  logic [COORD_W-1:0] ra_r, ra_nxt, rb_r, rb_nxt, ca_r, ca_nxt, cb_r, cb_nxt;
  logic [1:0]         widx_r, widx_nxt;
  logic               quad_r, quad_nxt;
  logic               err_r, err_nxt;

  logic [WALK_W-1:0]  rows_w, cols_w, rhi_w, chi_w, rlo_w, clo_w;
  logic [WALK_W-1:0]  j_dn, i_dn, j_up, i_up;
  logic [1:0]         widx_inc;
  logic [WALK_W-1:0]  nrow, ncol;
  logic [31:0]        cell_addr;

  assign rows_w = WALK_W'(rows);
  assign cols_w = WALK_W'(cols);
  assign rhi_w  = WALK_W'(row_hi);
  assign chi_w  = WALK_W'(col_hi);
  assign rlo_w  = WALK_W'(row_lo);
  assign clo_w  = WALK_W'(col_lo);

  assign j_dn = j_r - low_bit(j_r);
  assign i_dn = i_r - low_bit(i_r);
  assign j_up = j_r + low_bit(j_r);
  assign i_up = i_r + low_bit(i_r);

  // Walk k of a rectangle: bit 0 picks the lower row bound, bit 1 the lower column bound.
  assign widx_inc = widx_r + 2'd1;
  assign nrow = WALK_W'(widx_inc[0] ? rb_r : ra_r);
  assign ncol = WALK_W'(widx_inc[1] ? cb_r : ca_r);

  assign cell_addr = (32'(i_r) - 32'd1) * 32'(MAX_COLS) + 32'(j_r) - 32'd1;
  assign ram_addr  = (state_r == S_CLEAR) ? clr_r : cell_addr[AW-1:0];
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cstart_nxt = cstart_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    ca_nxt     = ca_r;
    cb_nxt     = cb_r;
    widx_nxt   = widx_r;
    quad_nxt   = quad_r;
    err_nxt    = err_r;
    ctl        = '0;

    case (state_r)
      S_CLEAR: begin
        ctl.wr      = 1'b1;
        ctl.wr_zero = 1'b1;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.start = 1'b1;
          err_nxt   = 1'b0;
          quad_nxt  = 1'b0;
          widx_nxt  = 2'd0;
          ra_nxt    = row_hi;
          ca_nxt    = col_hi;
          rb_nxt    = row_lo - 7'd1;
          cb_nxt    = col_lo - 7'd1;
          i_nxt     = rhi_w;
          j_nxt     = chi_w;
          cstart_nxt = chi_w;
          case (mode)
            MODE_ADD: begin
              if (row_hi != '0 && rhi_w <= rows_w && col_hi != '0 && chi_w <= cols_w) begin
                state_nxt = S_ADD_RD;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end
            end
            MODE_PREFIX: begin
              if (rhi_w <= rows_w && chi_w <= cols_w) begin
                state_nxt = S_WALK;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end
            end
            MODE_RECT: begin
              quad_nxt = 1'b1;
              if (row_lo != '0 && rlo_w <= rhi_w && rhi_w <= rows_w &&
                  col_lo != '0 && clo_w <= chi_w && chi_w <= cols_w) begin
                state_nxt = S_WALK;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end
            end
            MODE_WHOLE: begin
              ra_nxt     = rows;
              ca_nxt     = cols;
              i_nxt      = rows_w;
              j_nxt      = cols_w;
              cstart_nxt = cols_w;
              state_nxt  = S_WALK;
            end
            default: begin
              err_nxt   = 1'b1;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (i_r == '0 || j_r == '0) begin
          // End of one prefix walk; the last read is being accumulated in this cycle.
          if (quad_r && widx_r != 2'd3) begin
            widx_nxt   = widx_inc;
            i_nxt      = nrow;
            j_nxt      = ncol;
            cstart_nxt = ncol;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          ctl.rd     = 1'b1;
          ctl.acc    = 1'b1;
          ctl.rd_neg = (widx_r == 2'd1) || (widx_r == 2'd2);
          if (j_dn == '0) begin
            i_nxt = i_dn;
            j_nxt = cstart_r;
          end else begin
            j_nxt = j_dn;
          end
        end
      end
      S_ADD_RD: begin
        ctl.rd    = 1'b1;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        ctl.wr    = 1'b1;
        state_nxt = S_ADD_RD;
        if (j_up > cols_w) begin
          i_nxt = i_up;
          j_nxt = cstart_r;
          if (i_up > rows_w) begin
            state_nxt = S_DONE;
          end
        end else begin
          j_nxt = j_up;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ctl.fin   = 1'b1;
          ctl.err   = err_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_clear) begin
      state_nxt = S_CLEAR;
      clr_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    cstart_r <= cstart_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    ca_r     <= ca_nxt;
    cb_r     <= cb_nxt;
    widx_r   <= widx_nxt;
    quad_r   <= quad_nxt;
    err_r    <= err_nxt;
  end

endmodule

// File: sv/fenwick_tree_2d_core.sv
// Top level of the two-dimensional Fenwick tree core: configuration registers,
// accumulator, cell update datapath and output register. Uses fwt2d_pkg,
// fwt2d_seq and fwt2d_ram.
//
// The tree lives in one MAX_ROWS*MAX_COLS by 64-bit RAM with registered read.
// After reset and after every write to rows_in_use or cols_in_use the core
// zeroes all MAX_ROWS*MAX_COLS cells (4096 at 64 by 64) of the RAM in a
// clearing pass and accepts no item meanwhile. A query then reads one tree
// cell per step of each prefix walk (one walk for prefix and whole-grid
// sums, four for a rectangle), and a point add reads each cell updated and
// then writes it back. Every access goes through the single RAM port pair.
// A finished result waits in the output register while the next item is
// accepted. Out-of-range coordinates return status 1 and total 0.
module fenwick_tree_2d_core
  import fwt2d_pkg::*;
#(
  parameter int MAX_ROWS = FWT2D_MAX_ROWS,
  parameter int MAX_COLS = FWT2D_MAX_COLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // mode[1:0], row_lo[8:2], col_lo[15:9], row_hi[22:16], col_hi[29:23],
  // add_value[93:30], zero padding[95:94]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // total[63:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[0]
  output logic                   out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COORD_W-1:0] ROWS_RESET = COORD_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
  localparam logic [COORD_W-1:0] COLS_RESET = COORD_W'((MAX_COLS < 64) ? MAX_COLS : 64);

  logic [COORD_W-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic               cfg_clear;
  logic [COORD_W-1:0] rows_clamp, cols_clamp;

  logic [MODE_W-1:0]  in_mode;
  logic [COORD_W-1:0] in_row_lo, in_col_lo, in_row_hi, in_col_hi;
  logic [DATA_W-1:0]  in_add_value;

  fwt2d_ctl_t         ctl;
  logic [AW-1:0]      ram_addr;
  logic [DATA_W-1:0]  ram_rdata, ram_wdata;

  logic [DATA_W-1:0]  val_r, acc_r;
  logic               pend_r, pend_neg_r;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_total_r;
  logic               out_status_r;
  logic               out_free;

  assign in_mode      = in_tdata[1:0];
  assign in_row_lo    = in_tdata[8:2];
  assign in_col_lo    = in_tdata[15:9];
  assign in_row_hi    = in_tdata[22:16];
  assign in_col_hi    = in_tdata[29:23];
  assign in_add_value = in_tdata[93:30];

  // Size register writes saturate at the grid dimension and restart the clearing pass.
  assign cfg_ready  = 1'b1;
  assign rows_clamp = (32'(cfg_data) > MAX_ROWS) ? COORD_W'(MAX_ROWS) : cfg_data;
  assign cols_clamp = (32'(cfg_data) > MAX_COLS) ? COORD_W'(MAX_COLS) : cfg_data;

  always_comb begin
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    cfg_clear = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS_IN_USE: begin
          rows_nxt  = rows_clamp;
          cfg_clear = 1'b1;
        end
        CFG_COLS_IN_USE: begin
          cols_nxt  = cols_clamp;
          cfg_clear = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  assign out_free = !out_valid_r || out_tready;

  fwt2d_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_clear (cfg_clear),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .mode      (in_mode),
    .row_lo    (in_row_lo),
    .col_lo    (in_col_lo),
    .row_hi    (in_row_hi),
    .col_hi    (in_col_hi),
    .rows      (rows_r),
    .cols      (cols_r),
    .out_free  (out_free),
    .ram_addr  (ram_addr),
    .ctl       (ctl)
  );

  // In a point add the read data of the previous cycle is still on the port.
  assign ram_wdata = ctl.wr_zero ? '0 : (ram_rdata + val_r);

  fwt2d_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ctl.rd),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= ctl.acc;
      if (ctl.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_neg_r <= ctl.rd_neg;
    if (ctl.start) begin
      val_r <= in_add_value;
      acc_r <= '0;
    end else if (pend_r) begin
      acc_r <= pend_neg_r ? (acc_r - ram_rdata) : (acc_r + ram_rdata);
    end
    if (ctl.fin) begin
      out_total_r  <= ctl.err ? '0 : acc_r;
      out_status_r <= ctl.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_total_r;
  assign out_tuser  = out_status_r;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for fenwick_tree_2d_core: point adds and
// prefix, rectangle and whole-grid sums against an in-bench grid model.
// Depends on fwt2d_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench
  import fwt2d_pkg::*;
();

  localparam int  WATCHDOG_LIMIT   = 20000;
  localparam int  RANDOM_PER_PHASE = 115;
  localparam int  NUM_PHASES       = 10;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;
  localparam logic [DATA_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] row_lo;
    logic [COORD_W-1:0] col_lo;
    logic [COORD_W-1:0] row_hi;
    logic [COORD_W-1:0] col_hi;
    logic [DATA_W-1:0]  add_value;
  } grid_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] total;
    logic              status;
  } grid_sum_t;

  typedef struct {
    grid_op_t  op;
    bit        typed;
    grid_sum_t sum;
  } directed_row_t;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [COORD_W-1:0]     cfg_data;

  fenwick_tree_2d_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Grid model: tree cells stored row-major, 1-based walks.
  logic [DATA_W-1:0] tree_cell [FWT2D_MAX_ROWS*FWT2D_MAX_COLS];
  int rows_used;
  int cols_used;

  grid_sum_t pending_sums[$];
  grid_sum_t want_sum;
  directed_row_t directed[$];

  int mismatches;
  int items_sent;
  int sums_checked;
  int cfg_writes;
  int idle_cycles;
  int hold_request;

  always #5 clk = ~clk;

  function automatic void grid_clear();
    foreach (tree_cell[k]) tree_cell[k] = '0;
  endfunction

  function automatic int clamp_dim(logic [COORD_W-1:0] v, int max_dim);
    return (int'(v) > max_dim) ? max_dim : int'(v);
  endfunction

  function automatic logic [DATA_W-1:0] grid_prefix(int r, int c);
    logic [DATA_W-1:0] acc;
    int i;
    int j;
    acc = '0;
    if (r > rows_used) r = rows_used;
    if (c > cols_used) c = cols_used;
    for (i = r; i > 0; i -= i & -i)
      for (j = c; j > 0; j -= j & -j)
        acc += tree_cell[(i - 1) * FWT2D_MAX_COLS + (j - 1)];
    return acc;
  endfunction

  function automatic void grid_add(int r, int c, logic [DATA_W-1:0] v);
    int i;
    int j;
    for (i = r; i >= 1 && i <= rows_used; i += i & -i)
      for (j = c; j >= 1 && j <= cols_used; j += j & -j)
        tree_cell[(i - 1) * FWT2D_MAX_COLS + (j - 1)] += v;
  endfunction

  // Applies one operation to the model and returns the sum it answers.
  function automatic grid_sum_t grid_apply(grid_op_t op);
    grid_sum_t res;
    int rlo;
    int clo;
    int rhi;
    int chi;
    res.total  = '0;
    res.status = ST_OK;
    rlo = op.row_lo;
    clo = op.col_lo;
    rhi = op.row_hi;
    chi = op.col_hi;
    case (op.mode)
      MODE_ADD: begin
        if (rhi >= 1 && rhi <= rows_used && chi >= 1 && chi <= cols_used)
          grid_add(rhi, chi, op.add_value);
        else
          res.status = ST_RANGE;
      end
      MODE_PREFIX: begin
        if (rhi <= rows_used && chi <= cols_used)
          res.total = grid_prefix(rhi, chi);
        else
          res.status = ST_RANGE;
      end
      MODE_RECT: begin
        if (rlo >= 1 && rlo <= rhi && rhi <= rows_used &&
            clo >= 1 && clo <= chi && chi <= cols_used)
          res.total = grid_prefix(rhi, chi) - grid_prefix(rlo - 1, chi)
                    - grid_prefix(rhi, clo - 1) + grid_prefix(rlo - 1, clo - 1);
        else
          res.status = ST_RANGE;
      end
      default: res.total = grid_prefix(rows_used, cols_used);
    endcase
    return res;
  endfunction

  function automatic directed_row_t dir_row(logic [MODE_W-1:0] mode, int rlo, int clo,
                                            int rhi, int chi, logic [DATA_W-1:0] v,
                                            bit typed, logic [DATA_W-1:0] total,
                                            logic status);
    directed_row_t row;
    row.op.mode      = mode;
    row.op.row_lo    = rlo[COORD_W-1:0];
    row.op.col_lo    = clo[COORD_W-1:0];
    row.op.row_hi    = rhi[COORD_W-1:0];
    row.op.col_hi    = chi[COORD_W-1:0];
    row.op.add_value = v;
    row.typed        = typed;
    row.sum.total    = total;
    row.sum.status   = status;
    return row;
  endfunction

  // Mostly in-range coordinates with the edges favored; now and then one
  // past the grid so that range errors keep turning up.
  function automatic int pick_coord(int limit, bit allow_zero);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return $urandom_range(limit + 1, 127);
    if (roll == 1 && allow_zero) return 0;
    if (limit == 0) return 0;
    if (roll < 5) return 1;
    if (roll < 8) return limit;
    return $urandom_range(1, limit);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    int small_val;
    roll = $urandom_range(0, 9);
    small_val = $urandom_range(0, 16) - 8;
    if (roll == 0) return VAL_MAX;
    if (roll == 1) return VAL_MIN;
    if (roll < 5) return {{32{small_val[31]}}, small_val};
    return {$urandom, $urandom};
  endfunction

  function automatic grid_op_t random_op();
    grid_op_t op;
    int roll;
    int t;
    roll = $urandom_range(0, 99);
    op.row_lo    = COORD_W'($urandom_range(0, 127));
    op.col_lo    = COORD_W'($urandom_range(0, 127));
    op.row_hi    = COORD_W'($urandom_range(0, 127));
    op.col_hi    = COORD_W'($urandom_range(0, 127));
    op.add_value = {$urandom, $urandom};
    op.mode      = MODE_W'($urandom_range(0, 3));
    if (roll < 10) return op;
    if (roll < 45) begin
      op.mode      = MODE_ADD;
      op.row_hi    = COORD_W'(pick_coord(rows_used, 1'b0));
      op.col_hi    = COORD_W'(pick_coord(cols_used, 1'b0));
      op.add_value = pick_value();
    end else if (roll < 65) begin
      op.mode   = MODE_PREFIX;
      op.row_hi = COORD_W'(pick_coord(rows_used, 1'b1));
      op.col_hi = COORD_W'(pick_coord(cols_used, 1'b1));
    end else if (roll < 92) begin
      op.mode   = MODE_RECT;
      op.row_lo = COORD_W'(pick_coord(rows_used, 1'b1));
      op.row_hi = COORD_W'(pick_coord(rows_used, 1'b0));
      op.col_lo = COORD_W'(pick_coord(cols_used, 1'b1));
      op.col_hi = COORD_W'(pick_coord(cols_used, 1'b0));
      // Order the corners most of the time; a reversed pair is an error case.
      if (op.row_lo > op.row_hi && $urandom_range(0, 7) != 0) begin
        t = op.row_lo; op.row_lo = op.row_hi; op.row_hi = COORD_W'(t);
      end
      if (op.col_lo > op.col_hi && $urandom_range(0, 7) != 0) begin
        t = op.col_lo; op.col_lo = op.col_hi; op.col_hi = COORD_W'(t);
      end
    end else begin
      op.mode = MODE_WHOLE;
    end
    return op;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  task automatic send_op(grid_op_t op, bit typed, grid_sum_t typed_sum);
    grid_sum_t predicted;
    @(negedge clk);
    in_tdata  <= {2'b00, op.add_value, op.col_hi, op.row_hi, op.col_lo, op.row_lo, op.mode};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = grid_apply(op);
    pending_sums.push_back(typed ? typed_sum : predicted);
    items_sent++;
  endtask

  task automatic sender_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    sender_gap(1);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    drain_results();
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    // Writing a size register restarts the grid from zero.
    case (idx)
      CFG_ROWS_IN_USE: begin
        rows_used = clamp_dim(val, FWT2D_MAX_ROWS);
        grid_clear();
      end
      CFG_COLS_IN_USE: begin
        cols_used = clamp_dim(val, FWT2D_MAX_COLS);
        grid_clear();
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result: total %h status %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want_sum = pending_sums.pop_front();
        sums_checked++;
        if (out_tdata !== want_sum.total) begin
          $error("total mismatch: expected %h, actual %h", want_sum.total, out_tdata);
          mismatches++;
        end
        if (out_tuser !== want_sum.status) begin
          $error("status mismatch: expected %b, actual %b", want_sum.status, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result receiver: random back-pressure, calm stretches, and a long hold on request.
  initial begin
    int stall_left;
    int calm_left;
    int roll;
    stall_left = 0;
    calm_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 2)       calm_left  = $urandom_range(100, 300);
          else if (roll < 15) stall_left = $urandom_range(1, 3);
          else if (roll < 17) stall_left = $urandom_range(20, 80);
        end
      end
    end
  end

  initial begin
    int burst_left;
    int n_rows;
    int n_cols;
    grid_sum_t no_sum;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tdata     = '0;
    in_tvalid    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    items_sent   = 0;
    sums_checked = 0;
    cfg_writes   = 0;
    idle_cycles  = 0;
    hold_request = 0;
    burst_left   = 0;
    no_sum       = '0;
    rows_used    = FWT2D_MAX_ROWS;
    cols_used    = FWT2D_MAX_COLS;
    grid_clear();

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part on the reset-size grid.
    directed.push_back(dir_row(MODE_WHOLE,  0, 0,  0,  0, '0, 1, '0, ST_OK));
    directed.push_back(dir_row(MODE_PREFIX, 0, 0,  0,  0, '0, 1, '0, ST_OK));
    directed.push_back(dir_row(MODE_ADD,    0, 0,  1,  1, VAL_MAX, 1, '0, ST_OK));
    directed.push_back(dir_row(MODE_ADD,    0, 0, 64, 64, VAL_MIN, 1, '0, ST_OK));
    directed.push_back(dir_row(MODE_ADD,    0, 0,  0,  5, 64'd7, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_ADD,    0, 0,  5,  0, 64'd7, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_ADD,    0, 0, 65,  3, 64'd7, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_ADD,  127, 127, 3, 127, '1, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_PREFIX, 0, 0, 64, 64, '0, 0, '0, ST_OK));
    directed.push_back(dir_row(MODE_PREFIX, 0, 0, 65,  1, '0, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_PREFIX, 0, 0,  1, 127, '0, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_RECT,   1, 1, 64, 64, '0, 0, '0, ST_OK));
    directed.push_back(dir_row(MODE_RECT,   0, 1, 64, 64, '0, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_RECT,   9, 1,  8, 64, '0, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_RECT,   1, 9, 64,  8, '0, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_RECT,   1, 1, 65, 64, '0, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_RECT, 127, 127, 127, 127, '0, 1, '0, ST_RANGE));
    directed.push_back(dir_row(MODE_RECT,  64, 64, 64, 64, '0, 0, '0, ST_OK));
    directed.push_back(dir_row(MODE_ADD,    0, 0, 32, 17, '1, 1, '0, ST_OK));
    // Pushes the max-valued corner cell over the top.
    directed.push_back(dir_row(MODE_ADD,    0, 0,  1,  1, 64'd1, 1, '0, ST_OK));
    directed.push_back(dir_row(MODE_PREFIX, 0, 0,  1,  1, '0, 0, '0, ST_OK));
    directed.push_back(dir_row(MODE_RECT,  17, 10, 40, 33, '0, 0, '0, ST_OK));
    directed.push_back(dir_row(MODE_WHOLE, 127, 127, 127, 127, '1, 0, '0, ST_OK));
    foreach (directed[k]) begin
      send_op(directed[k].op, directed[k].typed, directed[k].sum);
      sender_gap(pick_gap());
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin n_rows = 1;   n_cols = 1;   end
        1: begin n_rows = 64;  n_cols = 64;  end
        2: begin n_rows = 0;   n_cols = 0;   end
        3: begin n_rows = 127; n_cols = 127; end
        4: begin n_rows = 5;   n_cols = 64;  end
        5: begin n_rows = 64;  n_cols = 3;   end
        6: begin n_rows = 0;   n_cols = 9;   end
        9: begin n_rows = 33;  n_cols = 100; end
        default: begin
          n_rows = $urandom_range(1, 64);
          n_cols = $urandom_range(1, 64);
        end
      endcase
      if (ph % 2 == 0) begin
        write_reg(CFG_ROWS_IN_USE, n_rows[COORD_W-1:0]);
        write_reg(CFG_COLS_IN_USE, n_cols[COORD_W-1:0]);
      end else begin
        write_reg(CFG_COLS_IN_USE, n_cols[COORD_W-1:0]);
        write_reg(CFG_ROWS_IN_USE, n_rows[COORD_W-1:0]);
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 1 && n == 30) begin
          // Hold the result side for a long stretch while items keep coming.
          hold_request = 600;
          burst_left   = 20;
        end
        if (ph == 1 && n == 60) begin
          // Writes to unknown indexes must leave the grid intact.
          write_reg(CFG_IDX_SPARE, COORD_W'($urandom_range(0, 127)));
          write_reg(CFG_IDX_TOP, COORD_W'($urandom_range(0, 127)));
        end
        if (ph == 4 && n == 50) drain_results();
        send_op(random_op(), 1'b0, no_sum);
        if (burst_left > 0) burst_left--;
        else sender_gap(pick_gap());
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (pending_sums.size() != 0) begin
      $error("%0d expected results never arrived", pending_sums.size());
      mismatches++;
    end

    $display("Ran %0d operations over %0d grid settings with %0d register writes;",
             items_sent, NUM_PHASES + 1, cfg_writes);
    $display("%0d sums and status codes compared, %0d discrepancies.",
             sums_checked, mismatches);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
sv/fwt2d_pkg.sv
sv/fwt2d_ram.sv
sv/fwt2d_seq.sv
sv/fenwick_tree_2d_core.sv
sim/testbench.sv
